### hdl/assert_macros.svh
// Assertion macros shared by the flash EEPROM emulator RTL.
// Included by the top level; SYNTH empties every macro body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hdl/fee_pkg.sv
// Package for the flash EEPROM emulator: constants, codes, sequencer states
// and the flash command struct. No dependencies.
`timescale 1ns / 1ps
package fee_pkg;

    localparam int unsigned PAGE_HALFWORDS_D = 512;
    localparam int unsigned PAGES_D          = 2;
    localparam int unsigned MIRRORS_D        = 2;

    localparam int unsigned MAP_W = 2;

    localparam logic [15:0] HDR_VALID = 16'hF0F0;
    localparam logic [15:0] ERASED    = 16'hFFFF;
    localparam logic [7:0]  CELL_HIGH = 8'hFF;
    localparam logic [MAP_W-1:0] NO_MIRROR = 2'd3;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_MOUNT = 2'd2,
        OP_RAW   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_RELOC = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL_EV,
        S_R_HDR,
        S_R_HDE,
        S_C_RS,
        S_C_RD,
        S_C_EV,
        S_R_FIN,
        S_R_MAP,
        S_W_RD,
        S_ERASE,
        S_M_RD,
        S_M_EV,
        S_M_NX,
        S_RESP
    } t_state;

    typedef struct packed {
        logic en;
        logic we;
    } t_mem_cmd;

endpackage

### hdl/fee_flash.sv
// Single-port flash array with a registered read, one access per cycle.
// Depends on fee_pkg for the command struct.
`timescale 1ns / 1ps
module fee_flash #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  fee_pkg::t_mem_cmd i_cmd,
    input  logic [AW-1:0]     i_addr,
    input  logic [15:0]       i_wdata,
    output logic [15:0]       o_rdata
);
    import fee_pkg::*;

    logic [15:0] mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            if (i_cmd.we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/flash_eeprom_emulator.sv
// Top level of the flash EEPROM emulator: decode, sequencer, page map.
// Depends on fee_pkg, fee_flash and assert_macros.svh.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+--------------------------------------------
//  in      | i_valid | o_ready | opcode, address, data_byte, raw_index,
//          |         |         | raw_value, last_of_request
//  out     | o_valid | i_ready | read_data, status, relocated, last_out
//
// Reads and in-place writes pass through accept (with the flash read), evaluate
// (the write, if any) and response. Raw preloads and rejected items go from
// accept (with the preload write) straight to response. A relocating write adds
// a page copy and page erases on the single flash port. Mount reads the header
// of every mirror of every page and erases each mirror whose header is neither
// erased nor the first valid one.
// After reset a clearing pass erases the whole flash; no transaction is
// accepted meanwhile. A stalled result waits in the output register while the
// next transaction may already be accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module flash_eeprom_emulator #(
    parameter int unsigned PAGE_HALFWORDS = fee_pkg::PAGE_HALFWORDS_D,
    parameter int unsigned PAGES          = fee_pkg::PAGES_D,
    parameter int unsigned MIRRORS        = fee_pkg::MIRRORS_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data_byte,
    input  logic [10:0] i_raw_index,
    input  logic [15:0] i_raw_value,
    input  logic        i_last_of_request,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic [1:0]  o_status,
    output logic        o_relocated,
    output logic        o_last_out
);
    import fee_pkg::*;

    localparam int unsigned FLASH_WORDS = MIRRORS * PAGES * PAGE_HALFWORDS;
    localparam int unsigned FW  = $clog2(FLASH_WORDS);
    localparam int unsigned OW  = $clog2(PAGE_HALFWORDS);
    localparam int unsigned PW  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int unsigned CPP = PAGE_HALFWORDS - 1;
    localparam int unsigned CAPACITY = PAGES * CPP;
    localparam logic [OW-1:0] LAST_C = OW'(PAGE_HALFWORDS - 1);

    // first halfword of a page in a given mirror
    function automatic logic [FW-1:0] base_of(input logic [MAP_W-1:0] m,
                                              input logic [PW-1:0] p);
        return FW'((32'(m) * PAGES + 32'(p)) * PAGE_HALFWORDS);
    endfunction

    t_state r_state, n_state, r_ret;

    // item registers
    t_opcode         r_op;
    logic [PW-1:0]   r_page;
    logic [OW-1:0]   r_off;
    logic [15:0]     r_want;
    logic            r_last;
    logic [MAP_W-1:0] r_mir, r_to, r_m, r_fm;
    logic [1:0]      r_n;
    logic            r_retry, r_found;
    logic [OW-1:0]   r_c;
    logic [15:0]     r_src;
    logic [FW-1:0]   r_cnt, r_ebase;
    logic [7:0]      r_rd;
    t_status         r_st;
    logic            r_rel;

    logic [MAP_W-1:0] r_map [PAGES];

    // output register
    logic        r_out_valid;
    logic [7:0]  r_o_rd;
    t_status     r_o_st;
    logic        r_o_rel, r_o_last;

    // flash port
    t_mem_cmd    mem_cmd;
    logic [FW-1:0] mem_addr;
    logic [15:0] mem_wdata, mem_rdata;

    fee_flash #(.DEPTH(FLASH_WORDS), .AW(FW)) u_flash (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    logic s_accept, s_out_free;
    assign o_ready    = (r_state == S_IDLE);
    assign s_accept   = i_valid && o_ready;
    assign s_out_free = !r_out_valid || i_ready;

    // Decode the virtual address: page by constant compares, then the offset.
    logic [PW-1:0]    d_page;
    logic [OW-1:0]    d_off;
    logic             d_in_range, d_mapped, d_raw_ok;
    logic [MAP_W-1:0] d_mir;

    always_comb begin
        int unsigned cnt;
        cnt = 0;
        for (int unsigned k = 1; k < PAGES; k++) begin
            cnt = cnt + ((32'(i_address) >= k * CPP) ? 1 : 0);
        end
        d_page     = PW'(cnt);
        d_off      = OW'(32'(i_address) - cnt * CPP + 1);
        d_in_range = (32'(i_address) < CAPACITY);
        d_mir      = r_map[d_page];
        d_mapped   = (32'(d_mir) < MIRRORS);
        d_raw_ok   = (32'(i_raw_index) < FLASH_WORDS);
    end

    logic [FW-1:0]    w_src_base, w_dst_base, w_cell;
    logic [MAP_W-1:0] w_next_mir;
    logic             w_last_m, w_last_p, w_hit, w_erased, w_c_skip;

    assign w_src_base = base_of(r_mir, r_page);
    assign w_dst_base = base_of(r_to, r_page);
    assign w_cell     = w_src_base + FW'(r_off);
    assign w_next_mir = (32'(r_mir) >= MIRRORS - 1) ? '0 : r_mir + MAP_W'(1);
    assign w_last_m   = (32'(r_m) == MIRRORS - 1);
    assign w_last_p   = (32'(r_page) == PAGES - 1);
    assign w_erased   = (mem_rdata == ERASED);
    assign w_hit      = (mem_rdata == r_want);
    assign w_c_skip   = (r_c == r_off);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (r_cnt == FW'(FLASH_WORDS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (s_accept) begin
                    unique case (t_opcode'(i_opcode))
                        OP_RAW:   n_state = S_RESP;
                        OP_MOUNT: n_state = S_M_RD;
                        default:  n_state = (d_in_range && d_mapped) ? S_CELL_EV : S_RESP;
                    endcase
                end
            end
            S_CELL_EV: begin
                if (r_op == OP_READ || w_hit || w_erased || 32'(r_n) >= MIRRORS) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_R_HDR;
                end
            end
            S_R_HDR:   n_state = S_R_HDE;
            S_R_HDE:   n_state = w_erased ? S_C_RS : S_ERASE;
            S_C_RS: begin
                if (w_c_skip) begin
                    n_state = (r_c == LAST_C) ? S_R_FIN : S_C_RS;
                end else begin
                    n_state = S_C_RD;
                end
            end
            S_C_RD:    n_state = S_C_EV;
            S_C_EV: begin
                if (mem_rdata == r_src || w_erased) begin
                    n_state = (r_c == LAST_C) ? S_R_FIN : S_C_RS;
                end else begin
                    n_state = r_retry ? S_RESP : S_ERASE;
                end
            end
            S_R_FIN:   n_state = S_ERASE;
            S_R_MAP:   n_state = S_W_RD;
            S_W_RD:    n_state = S_CELL_EV;
            S_ERASE:   if (r_cnt == FW'(PAGE_HALFWORDS - 1)) n_state = r_ret;
            S_M_RD:    n_state = S_M_EV;
            S_M_EV: begin
                if ((mem_rdata == HDR_VALID && !r_found) || w_erased) begin
                    n_state = S_M_NX;
                end else begin
                    n_state = S_ERASE;
                end
            end
            S_M_NX:    n_state = (w_last_m && w_last_p) ? S_RESP : S_M_RD;
            S_RESP:    if (s_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // flash port drive
    always_comb begin
        mem_cmd   = '0;
        mem_addr  = '0;
        mem_wdata = ERASED;
        unique case (r_state)
            S_CLEAR: begin
                mem_cmd  = '{en: 1'b1, we: 1'b1};
                mem_addr = r_cnt;
            end
            S_IDLE: begin
                if (s_accept) begin
                    if (t_opcode'(i_opcode) == OP_RAW) begin
                        if (d_raw_ok) begin
                            mem_cmd   = '{en: 1'b1, we: 1'b1};
                            mem_addr  = FW'(i_raw_index);
                            mem_wdata = i_raw_value;
                        end
                    end else if (t_opcode'(i_opcode) != OP_MOUNT && d_in_range && d_mapped) begin
                        mem_cmd  = '{en: 1'b1, we: 1'b0};
                        mem_addr = base_of(d_mir, d_page) + FW'(d_off);
                    end
                end
            end
            S_CELL_EV: begin
                if (r_op == OP_WRITE && !w_hit && w_erased) begin
                    mem_cmd   = '{en: 1'b1, we: 1'b1};
                    mem_addr  = w_cell;
                    mem_wdata = r_want;
                end
            end
            S_R_HDR: begin
                mem_cmd  = '{en: 1'b1, we: 1'b0};
                mem_addr = w_dst_base;
            end
            S_C_RS: begin
                if (!w_c_skip) begin
                    mem_cmd  = '{en: 1'b1, we: 1'b0};
                    mem_addr = w_src_base + FW'(r_c);
                end
            end
            S_C_RD: begin
                mem_cmd  = '{en: 1'b1, we: 1'b0};
                mem_addr = w_dst_base + FW'(r_c);
            end
            S_C_EV: begin
                if (mem_rdata != r_src && w_erased) begin
                    mem_cmd   = '{en: 1'b1, we: 1'b1};
                    mem_addr  = w_dst_base + FW'(r_c);
                    mem_wdata = r_src;
                end
            end
            S_R_FIN: begin
                mem_cmd   = '{en: 1'b1, we: 1'b1};
                mem_addr  = w_dst_base;
                mem_wdata = HDR_VALID;
            end
            S_W_RD: begin
                mem_cmd  = '{en: 1'b1, we: 1'b0};
                mem_addr = w_cell;
            end
            S_ERASE: begin
                mem_cmd  = '{en: 1'b1, we: 1'b1};
                mem_addr = r_ebase + r_cnt;
            end
            S_M_RD: begin
                mem_cmd  = '{en: 1'b1, we: 1'b0};
                mem_addr = base_of(r_m, r_page);
            end
            S_M_NX: begin
                if (w_last_m && !r_found) begin
                    mem_cmd   = '{en: 1'b1, we: 1'b1};
                    mem_addr  = base_of('0, r_page);
                    mem_wdata = HDR_VALID;
                end
            end
            default: ;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < PAGES; i++) r_map[i] <= NO_MIRROR;
        end else begin
            r_state <= n_state;
            // load the output register on a response, drop it once taken
            if (r_state == S_RESP && s_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: r_cnt <= r_cnt + FW'(1);
                S_IDLE: begin
                    if (s_accept) begin
                        r_op    <= t_opcode'(i_opcode);
                        r_page  <= (t_opcode'(i_opcode) == OP_MOUNT) ? '0 : d_page;
                        r_off   <= d_off;
                        r_want  <= {CELL_HIGH, i_data_byte};
                        r_last  <= i_last_of_request;
                        r_mir   <= d_mir;
                        r_n     <= '0;
                        r_rd    <= '0;
                        r_rel   <= 1'b0;
                        unique case (t_opcode'(i_opcode))
                            OP_RAW:   r_st <= d_raw_ok ? ST_OK : ST_RANGE;
                            OP_MOUNT: begin
                                r_st    <= ST_OK;
                                r_m     <= '0;
                                r_found <= 1'b0;
                            end
                            default:  r_st <= (d_in_range && d_mapped) ? ST_OK : ST_RANGE;
                        endcase
                    end
                end
                S_CELL_EV: begin
                    if (r_op == OP_READ) begin
                        r_rd <= mem_rdata[7:0];
                    end else if (!w_hit && !w_erased) begin
                        if (32'(r_n) >= MIRRORS) begin
                            r_st <= ST_RELOC;
                        end else begin
                            r_to    <= w_next_mir;
                            r_retry <= 1'b0;
                        end
                    end
                end
                S_R_HDE: begin
                    r_c <= OW'(1);
                    if (!w_erased) begin
                        r_ebase <= w_dst_base;
                        r_cnt   <= '0;
                        r_ret   <= S_C_RS;
                    end
                end
                S_C_RS: if (w_c_skip) r_c <= r_c + OW'(1);
                S_C_RD: r_src <= {CELL_HIGH, mem_rdata[7:0]};
                S_C_EV: begin
                    if (mem_rdata == r_src || w_erased) begin
                        r_c <= r_c + OW'(1);
                    end else if (r_retry) begin
                        r_st <= ST_RELOC;
                    end else begin
                        // conflict in the destination: wipe it and copy again
                        r_retry <= 1'b1;
                        r_c     <= OW'(1);
                        r_ebase <= w_dst_base;
                        r_cnt   <= '0;
                        r_ret   <= S_C_RS;
                    end
                end
                S_R_FIN: begin
                    r_ebase <= w_src_base;
                    r_cnt   <= '0;
                    r_ret   <= S_R_MAP;
                end
                S_R_MAP: begin
                    r_map[r_page] <= r_to;
                    r_mir         <= r_to;
                    r_rel         <= 1'b1;
                    r_n           <= r_n + 2'd1;
                end
                S_ERASE: r_cnt <= r_cnt + FW'(1);
                S_M_EV: begin
                    if (mem_rdata == HDR_VALID && !r_found) begin
                        r_found <= 1'b1;
                        r_fm    <= r_m;
                    end else if (!w_erased) begin
                        r_ebase <= base_of(r_m, r_page);
                        r_cnt   <= '0;
                        r_ret   <= S_M_NX;
                    end
                end
                S_M_NX: begin
                    if (w_last_m) begin
                        r_map[r_page] <= r_found ? r_fm : '0;
                        r_page        <= r_page + PW'(1);
                        r_m           <= '0;
                        r_found       <= 1'b0;
                    end else begin
                        r_m <= r_m + MAP_W'(1);
                    end
                end
                S_RESP: begin
                    if (s_out_free) begin
                        r_o_rd      <= r_rd;
                        r_o_st      <= r_st;
                        r_o_rel     <= r_rel;
                        r_o_last    <= r_last;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_o_rd;
    assign o_status    = r_o_st;
    assign o_relocated = r_o_rel;
    assign o_last_out  = r_o_last;

    // a transaction always moves out of the idle state in the cycle after it is accepted
    `ASSERT_CLK(a_accept_leaves_idle, i_clk, i_rst_n, (i_valid && o_ready) |=> (r_state != S_IDLE))
    // cell evaluation only ever runs against a mapped mirror
    `ASSERT_CLK(a_cell_mapped, i_clk, i_rst_n, (r_state == S_CELL_EV) |-> (32'(r_mir) < MIRRORS))
    // relocation never starts once the mirror budget is spent
    `ASSERT_CLK(a_reloc_bound, i_clk, i_rst_n, (r_state == S_R_HDR) |-> (32'(r_n) < MIRRORS))
    // page 0 map holds a real mirror or the empty code
    `ASSERT_NEVER(a_map_code, i_clk, i_rst_n, (r_map[0] != NO_MIRROR) && (32'(r_map[0]) >= MIRRORS))

endmodule
